### rtl/core/ptst_pkg.sv
// Package for the 32-bit primality tester.
// Holds the controller/datapath command and status types and fixed constants.
// No dependencies.
package ptst_pkg;

  // Range limits that choose the test method
  localparam logic [30:0] SMALL_LIMIT = 31'd1373653;
  localparam logic [30:0] MID_LIMIT   = 31'd9080191;

  // Miller-Rabin witness bases
  localparam logic [30:0] BASE_M0 = 31'd31;
  localparam logic [30:0] BASE_M1 = 31'd73;
  localparam logic [30:0] BASE_L0 = 31'd2;
  localparam logic [30:0] BASE_L1 = 31'd7;
  localparam logic [30:0] BASE_L2 = 31'd61;

  // Bits fed to the remainder unit per operand kind
  localparam logic [5:0] REM_BITS_VAL  = 6'd31;
  localparam logic [5:0] REM_BITS_PROD = 6'd62;

  // Remainder unit operand selection
  typedef enum logic [1:0] {
    REM_DIVM = 2'd0,
    REM_DIVP = 2'd1,
    REM_PROD = 2'd2
  } rem_sel_t;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_ACC_B = 2'd0,
    MUL_B_B   = 2'd1,
    MUL_X_X   = 2'd2
  } mul_sel_t;

  // Remainder write-back destination
  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_ACC  = 2'd1,
    WB_B    = 2'd2,
    WB_X    = 2'd3
  } wb_sel_t;

  typedef struct packed {
    logic     load;
    logic     rem_start;
    rem_sel_t rem_sel;
    logic     mul_en;
    mul_sel_t mul_sel;
    wb_sel_t  wb_sel;
    logic     td_init;
    logic     td_step;
    logic     mr_init;
    logic     d_shift;
    logic     wit_init;
    logic     e_shift;
    logic     x_from_acc;
    logic     r_inc;
    logic     w_clear;
    logic     w_inc;
  } ptst_cmd_t;

  typedef struct packed {
    logic neg;
    logic lt2;
    logic two_three;
    logic even;
    logic mult3;
    logic lt_small;
    logic rem_done;
    logic rem_zero;
    logic rem_one;
    logic td_more;
    logic d_even;
    logic e_zero;
    logic e_odd;
    logic r_lt_s;
    logic x_one;
    logic x_vm1;
    logic w_last;
  } ptst_sts_t;

endpackage

### rtl/core/ptst_if.sv
// Valid/ready channel interfaces of the primality tester.
// Depends on nothing; one interface per channel kind.
interface ptst_cand_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

interface ptst_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

### rtl/core/primality_tester_32bit_top.sv
// Usage: one signed 32-bit candidate enters on in_ch (valid/ready); one
// transaction on out_ch carries is_prime for it, in order.
// Negative values, values below 2, even values and multiples of 3 (other
// than 2 and 3) are settled by the screening step.
// Below 1373653 trial division by 6k-1 and 6k+1 runs in the bit-serial
// remainder unit, at most 195 divisor pairs. Larger values run two or
// three Miller-Rabin witnesses; each modular product is one multiply plus
// a serial reduction of the 62-bit product, and a witness needs at most
// about 61 products.
// One candidate is processed at a time; the serial remainder unit sets the
// pace. in_ch.ready is high only while the core is idle, so the next
// candidate can be taken in the cycle after the previous verdict is registered.
// A finished verdict sits in the output register; a new candidate is taken
// while it waits, and a second verdict waits until out_ch is drained.
// Synchronous active-low reset returns the core to idle and drops out_ch.valid.
// Depends on ptst_pkg, ptst_if, ptst_ctrl, ptst_dp.
module primality_tester_32bit_top
  import ptst_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  ptst_cand_if.sink   in_ch,
  ptst_res_if.source  out_ch
);

  ptst_cmd_t cmd;
  ptst_sts_t sts;

  ptst_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_is_prime (out_ch.is_prime),
    .sts          (sts),
    .cmd          (cmd)
  );

  ptst_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cand_in (in_ch.candidate),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule

### rtl/core/ptst_rem.sv
// Bit-serial remainder unit: one quotient bit per cycle, up to 62 dividend bits.
// Standalone; used by ptst_dp for trial division and modular reduction.
module ptst_rem (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] dividend,
  input  logic [5:0]  nbits,
  input  logic [30:0] modulus,
  output logic        done,
  output logic [30:0] rem
);

  logic [61:0] x_r;
  logic [30:0] rem_r;
  logic [30:0] m_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] trial;
  logic [31:0] rem_nxt;

  // Shift in next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, x_r[61]};
    if (trial >= {1'b0, m_r}) begin
      rem_nxt = trial - {1'b0, m_r};
    end else begin
      rem_nxt = trial;
    end
  end

  // Control: count bits, pulse done on the last one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= dividend;
      m_r   <= modulus;
      rem_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[60:0], 1'b0};
      rem_r <= rem_nxt[30:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/core/ptst_dp.sv
// Datapath of the primality tester: candidate, trial divisors, exponent,
// Miller-Rabin registers, multiplier and remainder unit. Uses ptst_pkg, ptst_rem.
module ptst_dp
  import ptst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] cand_in,
  input  ptst_cmd_t   cmd,
  output ptst_sts_t   sts
);

  logic [30:0] v_r;
  logic        neg_r;
  logic [61:0] p_r;
  logic [30:0] acc_r;
  logic [30:0] b_r;
  logic [30:0] x_r;
  logic [30:0] d_r;
  logic [30:0] e_r;
  logic [4:0]  s_r;
  logic [4:0]  r_r;
  logic [1:0]  w_r;
  logic [11:0] dm_r;
  logic [11:0] dp_r;
  logic [20:0] sq_r;

  logic [61:0] rem_x;
  logic [5:0]  rem_n;
  logic [30:0] rem_m;
  logic        rem_done;
  logic [30:0] rem_val;
  logic [30:0] op_a;
  logic [30:0] op_b;
  logic [30:0] base;
  logic        lt_mid;

  // Base-4 digits all weigh 1 mod 3, so their sum keeps the residue
  function automatic logic mult_of_three(logic [30:0] val);
    logic [31:0] ext;
    logic [5:0]  dsum;
    logic [3:0]  fsum;
    ext  = {1'b0, val};
    dsum = '0;
    for (int i = 0; i < 16; i++) begin
      dsum = dsum + 6'(ext[2*i +: 2]);
    end
    fsum = 4'(dsum[5:4]) + 4'(dsum[3:2]) + 4'(dsum[1:0]);
    return (fsum == 4'd0) || (fsum == 4'd3) || (fsum == 4'd6) || (fsum == 4'd9);
  endfunction

  assign lt_mid = v_r < MID_LIMIT;

  // Select witness base
  always_comb begin
    base = BASE_L0;
    if (lt_mid) begin
      base = (w_r == 2'd0) ? BASE_M0 : BASE_M1;
    end else begin
      case (w_r)
        2'd0:    base = BASE_L0;
        2'd1:    base = BASE_L1;
        default: base = BASE_L2;
      endcase
    end
  end

  // Select remainder operands
  always_comb begin
    rem_x = {v_r, 31'd0};
    rem_n = REM_BITS_VAL;
    rem_m = {19'd0, dm_r};
    unique case (cmd.rem_sel)
      REM_DIVM: rem_m = {19'd0, dm_r};
      REM_DIVP: rem_m = {19'd0, dp_r};
      REM_PROD: begin
        rem_x = p_r;
        rem_n = REM_BITS_PROD;
        rem_m = v_r;
      end
      default: ;
    endcase
  end

  // Select multiplier operands
  always_comb begin
    op_a = acc_r;
    op_b = b_r;
    case (cmd.mul_sel)
      MUL_ACC_B: begin op_a = acc_r; op_b = b_r; end
      MUL_B_B:   begin op_a = b_r;   op_b = b_r; end
      default:   begin op_a = x_r;   op_b = x_r; end
    endcase
  end

  ptst_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (rem_x),
    .nbits    (rem_n),
    .modulus  (rem_m),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // Hold candidate, trial-division and Miller-Rabin registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r   <= cand_in[30:0];
      neg_r <= cand_in[31];
    end
    if (cmd.mul_en) begin
      p_r <= 62'(op_a) * 62'(op_b);
    end
    if (cmd.td_init) begin
      dm_r <= 12'd5;
      dp_r <= 12'd7;
      sq_r <= 21'd24;
    end else if (cmd.td_step) begin
      dm_r <= dm_r + 12'd6;
      dp_r <= dp_r + 12'd6;
      sq_r <= sq_r + 21'(dm_r) * 21'd12 + 21'd36;
    end
    if (cmd.mr_init) begin
      d_r <= v_r - 31'd1;
      s_r <= '0;
    end else if (cmd.d_shift) begin
      d_r <= d_r >> 1;
      s_r <= s_r + 5'd1;
    end
    if (cmd.w_clear) begin
      w_r <= '0;
    end else if (cmd.w_inc) begin
      w_r <= w_r + 2'd1;
    end
    if (cmd.wit_init) begin
      acc_r <= 31'd1;
      b_r   <= base;
      e_r   <= d_r;
      r_r   <= '0;
    end else begin
      if (cmd.e_shift) e_r <= e_r >> 1;
      if (cmd.r_inc)   r_r <= r_r + 5'd1;
      if (cmd.x_from_acc) x_r <= acc_r;
      case (cmd.wb_sel)
        WB_ACC:  acc_r <= rem_val;
        WB_B:    b_r   <= rem_val;
        WB_X:    x_r   <= rem_val;
        default: ;
      endcase
    end
  end

  // Status towards the controller
  always_comb begin
    sts.neg       = neg_r;
    sts.lt2       = v_r < 31'd2;
    sts.two_three = (v_r == 31'd2) || (v_r == 31'd3);
    sts.even      = !v_r[0];
    sts.mult3     = mult_of_three(v_r);
    sts.lt_small  = v_r < SMALL_LIMIT;
    sts.rem_done  = rem_done;
    sts.rem_zero  = rem_val == 31'd0;
    sts.rem_one   = rem_val == 31'd1;
    sts.td_more   = {10'd0, sq_r} < v_r;
    sts.d_even    = !d_r[0];
    sts.e_zero    = e_r == 31'd0;
    sts.e_odd     = e_r[0];
    sts.r_lt_s    = r_r < s_r;
    sts.x_one     = x_r == 31'd1;
    sts.x_vm1     = x_r == (v_r - 31'd1);
    sts.w_last    = lt_mid ? (w_r == 2'd1) : (w_r == 2'd2);
  end

endmodule

### rtl/core/ptst_ctrl.sv
// Controller of the primality tester: sequences screening, trial division and
// Miller-Rabin rounds; owns the result register. Uses ptst_pkg.
module ptst_ctrl
  import ptst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output logic      out_is_prime,
  input  ptst_sts_t sts,
  output ptst_cmd_t cmd
);

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_CLASS = 16'h0002,
    ST_TDCHK = 16'h0004,
    ST_TDP   = 16'h0008,
    ST_TDM   = 16'h0010,
    ST_MRD   = 16'h0020,
    ST_WINIT = 16'h0040,
    ST_ECHK  = 16'h0080,
    ST_MULA  = 16'h0100,
    ST_WA    = 16'h0200,
    ST_MULB  = 16'h0400,
    ST_WB    = 16'h0800,
    ST_SQCHK = 16'h1000,
    ST_MULX  = 16'h2000,
    ST_WX    = 16'h4000,
    ST_FIN   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_res_r, out_res_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    cmd           = '0;
    cmd.rem_sel   = REM_DIVM;
    cmd.mul_sel   = MUL_ACC_B;
    cmd.wb_sel    = WB_NONE;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (sts.neg || sts.lt2) begin
          res_nxt = 1'b0; state_nxt = ST_FIN;
        end else if (sts.two_three) begin
          res_nxt = 1'b1; state_nxt = ST_FIN;
        end else if (sts.even || sts.mult3) begin
          res_nxt = 1'b0; state_nxt = ST_FIN;
        end else if (sts.lt_small) begin
          cmd.td_init = 1'b1; state_nxt = ST_TDCHK;
        end else begin
          cmd.mr_init = 1'b1; state_nxt = ST_MRD;
        end
      end
      ST_TDCHK: begin
        if (!sts.td_more) begin
          res_nxt = 1'b1; state_nxt = ST_FIN;
        end else begin
          cmd.rem_start = 1'b1;
          cmd.rem_sel   = REM_DIVP;
          state_nxt     = ST_TDP;
        end
      end
      ST_TDP: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            res_nxt = 1'b0; state_nxt = ST_FIN;
          end else begin
            cmd.rem_start = 1'b1;
            cmd.rem_sel   = REM_DIVM;
            state_nxt     = ST_TDM;
          end
        end
      end
      ST_TDM: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            res_nxt = 1'b0; state_nxt = ST_FIN;
          end else begin
            cmd.td_step = 1'b1; state_nxt = ST_TDCHK;
          end
        end
      end
      // Strip factors of two from v-1
      ST_MRD: begin
        if (sts.d_even) begin
          cmd.d_shift = 1'b1;
        end else begin
          cmd.w_clear = 1'b1; state_nxt = ST_WINIT;
        end
      end
      ST_WINIT: begin
        cmd.wit_init = 1'b1; state_nxt = ST_ECHK;
      end
      // Square-and-multiply over the odd exponent
      ST_ECHK: begin
        if (sts.e_zero) begin
          cmd.x_from_acc = 1'b1; state_nxt = ST_SQCHK;
        end else if (sts.e_odd) begin
          cmd.mul_en = 1'b1; cmd.mul_sel = MUL_ACC_B; state_nxt = ST_MULA;
        end else begin
          cmd.mul_en = 1'b1; cmd.mul_sel = MUL_B_B; state_nxt = ST_MULB;
        end
      end
      ST_MULA: begin
        cmd.rem_start = 1'b1; cmd.rem_sel = REM_PROD; state_nxt = ST_WA;
      end
      ST_WA: begin
        if (sts.rem_done) begin
          cmd.wb_sel  = WB_ACC;
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MUL_B_B;
          state_nxt   = ST_MULB;
        end
      end
      ST_MULB: begin
        cmd.rem_start = 1'b1; cmd.rem_sel = REM_PROD; state_nxt = ST_WB;
      end
      ST_WB: begin
        if (sts.rem_done) begin
          cmd.wb_sel  = WB_B;
          cmd.e_shift = 1'b1;
          state_nxt   = ST_ECHK;
        end
      end
      // Repeated squaring of the witness value
      ST_SQCHK: begin
        if (sts.r_lt_s) begin
          cmd.mul_en = 1'b1; cmd.mul_sel = MUL_X_X; state_nxt = ST_MULX;
        end else if (!sts.x_one) begin
          res_nxt = 1'b0; state_nxt = ST_FIN;
        end else if (sts.w_last) begin
          res_nxt = 1'b1; state_nxt = ST_FIN;
        end else begin
          cmd.w_inc = 1'b1; state_nxt = ST_WINIT;
        end
      end
      ST_MULX: begin
        cmd.rem_start = 1'b1; cmd.rem_sel = REM_PROD; state_nxt = ST_WX;
      end
      ST_WX: begin
        if (sts.rem_done) begin
          if (sts.rem_one && !sts.x_one && !sts.x_vm1) begin
            res_nxt = 1'b0; state_nxt = ST_FIN;
          end else begin
            cmd.wb_sel = WB_X; cmd.r_inc = 1'b1; state_nxt = ST_SQCHK;
          end
        end
      end
      // Hand the verdict to the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ready     = state_r == ST_IDLE;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_res_r;

`ifndef SYNTHESIS
  a_no_rem_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !sts.rem_done)
    else $error("remainder completion while idle");
  a_rem_multicycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_start |=> !sts.rem_done)
    else $error("remainder finished in one cycle");
  a_exp_to_square: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ECHK) && sts.e_zero |=> (state_r == ST_SQCHK))
    else $error("exponent done without entering squaring");
  a_fin_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && $past(state_r != ST_FIN) |-> !$past(state_r == ST_IDLE))
    else $error("verdict without processing");
`endif

endmodule

### tb/ptst_tb_checker.sv
`timescale 1ns / 100ps
// Checker for the primality tester: watches both channels, predicts is_prime
// for each accepted candidate and compares it with each accepted verdict.
// Depends on ptst_if (channel interfaces).
module ptst_tb_checker (
  input  logic         clk,
  input  logic         rst_n,
  ptst_cand_if.sink    cand_mon,
  ptst_res_if.sink     res_mon,
  output int           fail_count,
  output int           verdicts_pending,
  output int           primes_seen,
  output int           verdicts_seen
);

  bit verdict_q[$];

  // Modular product of two residues below m, 62-bit products
  function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned m);
    return (a * b) % m;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned m);
    longint unsigned acc;
    acc = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, b, m);
      b = mod_mul(b, b, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  // True when witness w shows odd m composite
  function automatic bit witness_fails(longint unsigned w, longint unsigned m);
    longint unsigned d, x, y;
    int s;
    d = m - 1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    x = mod_pow(w, d, m);
    for (int r = 0; r < s; r++) begin
      y = mod_mul(x, x, m);
      if (y == 1 && x != 1 && x != m - 1) return 1'b1;
      x = y;
    end
    return x != 1;
  endfunction

  function automatic bit predict_prime(logic signed [31:0] cand);
    longint unsigned v;
    if (cand[31]) return 1'b0;
    v = longint'(cand[30:0]);
    if (v < 2) return 1'b0;
    if (v == 2 || v == 3) return 1'b1;
    if (v[0] == 1'b0 || v % 3 == 0) return 1'b0;
    if (v < 1373653) begin
      for (longint unsigned k = 1; 36 * k * k - 12 * k < v; k++)
        if (v % (6 * k + 1) == 0 || v % (6 * k - 1) == 0) return 1'b0;
      return 1'b1;
    end
    if (v < 9080191) return !(witness_fails(31, v) || witness_fails(73, v));
    return !(witness_fails(2, v) || witness_fails(7, v) || witness_fails(61, v));
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    fail_count++;
  endtask

  assign verdicts_pending = verdict_q.size();

  // Clear counts in reset; predict on each candidate transaction, compare on
  // each verdict transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      primes_seen = 0;
      verdicts_seen = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with no candidate outstanding");
        end else begin
          if (verdict_q[0] != res_mon.is_prime)
            report_mismatch($sformatf("is_prime got %0b want %0b",
                                      res_mon.is_prime, verdict_q[0]));
          primes_seen += verdict_q[0];
          void'(verdict_q.pop_front());
        end
      end
      if (cand_mon.valid && cand_mon.ready)
        verdict_q = {verdict_q, predict_prime(cand_mon.candidate)};
    end
  end

endmodule

### tb/tb_primality_tester_32bit_top.sv
`timescale 1ns / 100ps
// Top of the primality tester testbench: clock, reset, candidate stimulus,
// receiver stalls and verdict. Depends on ptst_if, ptst_tb_checker and the block.
module tb_primality_tester_32bit_top;

  localparam longint CYCLE_LIMIT = 64'd8000000;
  localparam int     HOLD_CYCLES = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   fail_count, verdicts_pending, primes_seen, verdicts_seen;
  longint cycle_count = 0;

  ptst_cand_if cand_ch ();
  ptst_res_if  res_ch ();

  primality_tester_32bit_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cand_ch.sink),
    .out_ch (res_ch.source)
  );

  ptst_tb_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cand_mon         (cand_ch.sink),
    .res_mon          (res_ch.sink),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending),
    .primes_seen      (primes_seen),
    .verdicts_seen    (verdicts_seen)
  );

  always #5 clk = ~clk;

  initial begin
    cand_ch.valid = 1'b0;
    cand_ch.candidate = '0;
    res_ch.ready = 1'b0;
  end

  // Abort on a run that never settles
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Drive receiver readiness at the falling edge
  always @(negedge clk) begin
    if (!rst_n || hold_off)
      res_ch.ready <= 1'b0;
    else
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one candidate, idling at random beforehand; hold until accepted.
  // Valid stays up after acceptance so back-to-back offers need no gap.
  task automatic send_candidate(logic signed [31:0] cand);
    while ($urandom_range(99) < send_idle_pct) begin
      cand_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cand_ch.valid <= 1'b1;
    cand_ch.candidate <= cand;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Often small, otherwise near the top of trial division, from the Miller-Rabin ranges, negative or anywhere
  function automatic logic signed [31:0] random_candidate();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom_range(2000);
    if (pick < 55) return $urandom_range(1373652, 1300000);
    if (pick < 70) return $urandom_range(9080190, 1373653);
    if (pick < 85) return $urandom_range(32'h7fffffff, 9080191);
    if (pick < 90) return -$signed($urandom_range(1000));
    return $urandom;
  endfunction

  // Drop valid and wait until every expected verdict has come back
  task automatic wait_drained();
    cand_ch.valid <= 1'b0;
    @(negedge clk);
    while (verdicts_pending != 0) @(negedge clk);
  endtask

  initial begin
    logic signed [31:0] directed [$] = '{
      32'sh80000000, -1, 0, 1, 2, 3, 4, 9, 25, 49, 97, 121, 1373651, 1373653,
      1373659, 9080191, 9080189, 32'd3215031751, 2147483647, 2147483646,
      2147483629, 32'h55555555, 32'h2aaaaaab, 1000003};
    int phase_idle [4] = '{0, 62, 0, 62};
    int phase_stall[4] = '{0, 0, 62, 62};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners: limits, odd squares, Carmichael-like and bit patterns
    foreach (directed[i]) send_candidate(directed[i]);
    wait_drained();

    // Random phases with varied idling on both sides
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = (p == 3) ? 6 : phase_stall[p];
      if (p == 3) send_idle_pct = 6;
      for (int n = 0; n < 20; n++) send_candidate(random_candidate());
      // Sender pauses until every verdict is back
      wait_drained();
    end

    // Receiver holds off while the sender keeps offering small candidates
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 6; n++) send_candidate($urandom_range(500));
    join
    wait_drained();
    repeat (14000) @(posedge clk);

    $display("Ran %0d verdicts (%0d prime) over four idling mixes and a long hold-off",
             verdicts_seen, primes_seen);
    if (fail_count == 0 && verdicts_pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
